FILE: src/smb_pkg.sv
// Shared types and constants for the selective receive mailbox.
package smb_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int MAX_SELECTORS = 4;
  localparam int SEL_FIELDS    = 4;
  localparam int SEL_LIM       = (MAX_SELECTORS < SEL_FIELDS) ? MAX_SELECTORS : SEL_FIELDS;
  localparam int ADDR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [2:0] STAT_ADDED   = 3'd0;
  localparam logic [2:0] STAT_FULL    = 3'd1;
  localparam logic [2:0] STAT_FOUND   = 3'd2;
  localparam logic [2:0] STAT_NOMATCH = 3'd3;
  localparam logic [2:0] STAT_CLEARED = 3'd4;

  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [15:0] ref_id;
    logic [15:0] sender;
    logic [31:0] signal;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] entry_ref;
    logic [15:0] entry_sender;
    logic [31:0] entry_signal;
    logic        match_sender;
    logic [15:0] wanted_sender;
    logic [2:0]  sel_count;
    logic [31:0] sel_id0;
    logic [31:0] sel_id1;
    logic [31:0] sel_id2;
    logic [31:0] sel_id3;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_ref;
    logic [15:0] found_sender;
    logic [31:0] found_signal;
    logic [4:0]  occupancy;
  } out_item_t;

endpackage

FILE: src/smb_if.sv
// Valid/ready channel interfaces for mailbox requests and responses.
interface smb_in_if;
  logic               valid;
  logic               ready;
  smb_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface smb_out_if;
  logic               valid;
  logic               ready;
  smb_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/smb_match.sv
// Entry filter compare: sender filter and wanted signal id set.
module smb_match (
  input  smb_pkg::entry_t   entry,
  input  smb_pkg::in_item_t item,
  output logic              hit
);

  logic [31:0] sel [smb_pkg::SEL_FIELDS];
  logic [2:0]  n;
  logic        sig_hit;
  logic        snd_ok;

  always_comb begin
    sel[0] = item.sel_id0;
    sel[1] = item.sel_id1;
    sel[2] = item.sel_id2;
    sel[3] = item.sel_id3;
    n = (item.sel_count > 3'(smb_pkg::SEL_LIM)) ? 3'(smb_pkg::SEL_LIM) : item.sel_count;
    sig_hit = 1'b0;
    for (int k = 0; k < smb_pkg::SEL_FIELDS; k++) begin
      if ((3'(k) < n) && (entry.signal == sel[k])) begin
        sig_hit = 1'b1;
      end
    end
    snd_ok = !item.match_sender || (entry.sender == item.wanted_sender);
    hit = snd_ok && ((n == 3'd0) || sig_hit);
  end

endmodule

FILE: src/selective_receive_mailbox_unit.sv
// Top level of the selective receive mailbox: entry store, scan and compaction sequencer.
//
//   channel | dir | payload                                   | handshake
//   req     | in  | kind, entry, sender filter, signal id set | valid/ready
//   rsp     | out | status, found entry, occupancy            | valid/ready
//   cfg     | in  | capacity_limit                            | cfg_we only
//
// Add, clear and unused kinds go from accept straight to the response state and load the response there.
// A get reads one entry a cycle; with no match it loads a NOMATCH response, and on a hit it
// loads the response after the entries above the hit shift down one place to close the gap.
// rst clears occupancy and the response valid flag, and sets capacity to 16.
// req is taken only when the sequencer is idle; a held response blocks only the next load.
module selective_receive_mailbox_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [4:0]      cfg_data,
  smb_in_if.sink          req,
  smb_out_if.source       rsp
);

  smb_pkg::state_t    state, state_next;
  smb_pkg::in_item_t  item, item_next;
  smb_pkg::entry_t    found, found_next;
  smb_pkg::entry_t    rd_data;
  smb_pkg::out_item_t out_data, out_data_next;
  smb_pkg::entry_t    mem [smb_pkg::QUEUE_DEPTH];

  logic [smb_pkg::CNT_W-1:0]  count, count_next;
  logic [smb_pkg::CNT_W-1:0]  ptr, ptr_next;
  logic [smb_pkg::ADDR_W-1:0] hit_addr, hit_addr_next;
  logic [smb_pkg::ADDR_W-1:0] wptr, wptr_next;
  logic [4:0]                 cap, cap_next;
  logic [2:0]                 get_stat, get_stat_next;
  logic                       pend, pend_next;
  logic                       out_valid, out_valid_next;
  logic                       out_free;
  logic                       hit;
  logic                       mem_we;
  logic [smb_pkg::ADDR_W-1:0] mem_wa;
  smb_pkg::entry_t            mem_wd;
  logic                       rd_en;
  logic [smb_pkg::ADDR_W-1:0] rd_addr;

  smb_match u_match (
    .entry (rd_data),
    .item  (item),
    .hit   (hit)
  );

  assign req.ready = (state == smb_pkg::ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;
  assign out_free  = !out_valid || rsp.ready;

  always_comb begin
    state_next     = state;
    item_next      = item;
    found_next     = found;
    count_next     = count;
    ptr_next       = ptr;
    hit_addr_next  = hit_addr;
    wptr_next      = wptr;
    get_stat_next  = get_stat;
    pend_next      = pend;
    cap_next       = cfg_we ? cfg_data : cap;
    out_valid_next = out_valid && !rsp.ready;
    out_data_next  = out_data;
    mem_we         = 1'b0;
    mem_wa         = count[smb_pkg::ADDR_W-1:0];
    mem_wd         = '{ref_id: item.entry_ref, sender: item.entry_sender,
                       signal: item.entry_signal};
    rd_en          = 1'b0;
    rd_addr        = ptr[smb_pkg::ADDR_W-1:0];

    unique case (state)
      smb_pkg::ST_IDLE: begin
        if (req.valid) begin
          item_next  = req.data;
          ptr_next   = '0;
          pend_next  = 1'b0;
          state_next = (req.data.kind == smb_pkg::KIND_GET) ? smb_pkg::ST_SCAN
                                                             : smb_pkg::ST_RESP;
        end
      end
      smb_pkg::ST_SCAN: begin
        if (pend && hit) begin
          found_next = rd_data;
          wptr_next  = hit_addr;
          ptr_next   = smb_pkg::CNT_W'({1'b0, hit_addr}) + smb_pkg::CNT_W'(1);
          pend_next  = 1'b0;
          state_next = smb_pkg::ST_SHIFT;
        end else if (ptr < count) begin
          rd_en         = 1'b1;
          hit_addr_next = ptr[smb_pkg::ADDR_W-1:0];
          ptr_next      = ptr + smb_pkg::CNT_W'(1);
          pend_next     = 1'b1;
        end else begin
          get_stat_next = smb_pkg::STAT_NOMATCH;
          state_next    = smb_pkg::ST_RESP;
        end
      end
      smb_pkg::ST_SHIFT: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_wa    = wptr;
          mem_wd    = rd_data;
          wptr_next = wptr + smb_pkg::ADDR_W'(1);
        end
        if (ptr < count) begin
          rd_en     = 1'b1;
          ptr_next  = ptr + smb_pkg::CNT_W'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next    = count - smb_pkg::CNT_W'(1);
            get_stat_next = smb_pkg::STAT_FOUND;
            state_next    = smb_pkg::ST_RESP;
          end
        end
      end
      smb_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_next              = 1'b1;
          out_data_next.found_ref     = '0;
          out_data_next.found_sender  = '0;
          out_data_next.found_signal  = '0;
          out_data_next.status        = smb_pkg::STAT_NOMATCH;
          out_data_next.occupancy     = count;
          state_next                  = smb_pkg::ST_IDLE;
          case (item.kind)
            smb_pkg::KIND_ADD: begin
              if ((count < smb_pkg::CNT_W'(cap)) &&
                  (count < smb_pkg::CNT_W'(smb_pkg::QUEUE_DEPTH))) begin
                mem_we                  = 1'b1;
                count_next              = count + smb_pkg::CNT_W'(1);
                out_data_next.status    = smb_pkg::STAT_ADDED;
                out_data_next.occupancy = count + smb_pkg::CNT_W'(1);
              end else begin
                out_data_next.status    = smb_pkg::STAT_FULL;
              end
            end
            smb_pkg::KIND_GET: begin
              out_data_next.status = get_stat;
              if (get_stat == smb_pkg::STAT_FOUND) begin
                out_data_next.found_ref    = found.ref_id;
                out_data_next.found_sender = found.sender;
                out_data_next.found_signal = found.signal;
              end
            end
            smb_pkg::KIND_CLEAR: begin
              count_next              = '0;
              out_data_next.status    = smb_pkg::STAT_CLEARED;
              out_data_next.occupancy = '0;
            end
            default: begin
              out_data_next.status = smb_pkg::STAT_NOMATCH;
            end
          endcase
        end
      end
      default: begin
        state_next = smb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smb_pkg::ST_IDLE;
      count     <= '0;
      cap       <= smb_pkg::CAP_RESET;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cap       <= cap_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    found    <= found_next;
    ptr      <= ptr_next;
    hit_addr <= hit_addr_next;
    wptr     <= wptr_next;
    get_stat <= get_stat_next;
    out_data <= out_data_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
